FILE: rtl/core/slip_mux_receive_deframer_unit_assert.svh
// Assertion macros for the SLIP mux deframer.
// The enclosing module supplies clk and arst_n.
`ifndef SLIP_MUX_RECEIVE_DEFRAMER_UNIT_ASSERT_SVH
`define SLIP_MUX_RECEIVE_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SMRD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SMRD_ASSERT(lbl, prop, msg)
`define SMRD_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/core/smrd_pkg.sv
`default_nettype none
package smrd_pkg;

	localparam logic [7:0] B_END     = 8'hC0;
	localparam logic [7:0] B_ESC     = 8'hDB;
	localparam logic [7:0] B_ESC_END = 8'hDC;
	localparam logic [7:0] B_ESC_ESC = 8'hDD;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_STDIO_EN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COAP_EN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NET_EN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STDIO_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COAP_START  = 3'd4;

	localparam logic [1:0] CH_TEXT = 2'd0;
	localparam logic [1:0] CH_COAP = 2'd1;
	localparam logic [1:0] CH_NET  = 2'd2;

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		M_IDLE     = 3'd0,
		M_SKIP     = 3'd1,
		M_TEXT     = 3'd2,
		M_TEXT_ESC = 3'd3,
		M_COAP     = 3'd4,
		M_COAP_ESC = 3'd5,
		M_NET      = 3'd6,
		M_NET_ESC  = 3'd7
	} mode_t;

	typedef struct packed {
		logic       stdio_enable;
		logic       coap_enable;
		logic       net_enable;
		logic [7:0] stdio_start_byte;
		logic [7:0] coap_start_byte;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] unesc;
		logic       is_end;
		logic       is_esc;
		logic       is_stdio_start;
		logic       is_coap_start;
		logic       is_net_start;
		logic       coap_can_start;
		logic       coap_can_add;
		logic       net_can_start;
		logic       net_can_add;
	} cls_t;

	typedef struct packed {
		logic       deliver;
		logic [1:0] channel;
		logic [7:0] out_data;
		logic       frame_open;
		logic       frame_commit;
		logic       frame_drop;
	} res_t;

	function automatic logic [7:0] unescape(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b == B_ESC_END) r = B_END;
		else if (b == B_ESC_ESC) r = B_ESC;
		return r;
	endfunction

	// IPv4 0x45..0x4F, IPv6 0x60..0x6F
	function automatic logic net_start(input logic [7:0] b);
		return ((b >= 8'h45) && (b <= 8'h4F)) || ((b >= 8'h60) && (b <= 8'h6F));
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/smrd_in_if.sv
`default_nettype none
interface smrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       coap_can_start;
	logic       coap_can_add;
	logic       net_can_start;
	logic       net_can_add;

	modport source(output valid, output rx_byte, output coap_can_start, output coap_can_add,
		output net_can_start, output net_can_add, input ready);
	modport sink(input valid, input rx_byte, input coap_can_start, input coap_can_add,
		input net_can_start, input net_can_add, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/smrd_out_if.sv
`default_nettype none
interface smrd_out_if;
	logic       valid;
	logic       ready;
	logic       deliver;
	logic [1:0] channel;
	logic [7:0] out_data;
	logic       frame_open;
	logic       frame_commit;
	logic       frame_drop;

	modport source(output valid, output deliver, output channel, output out_data,
		output frame_open, output frame_commit, output frame_drop, input ready);
	modport sink(input valid, input deliver, input channel, input out_data,
		input frame_open, input frame_commit, input frame_drop, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/smrd_front.sv
`default_nettype none
module smrd_front (
	smrd_in_if.sink         byte_ch,
	input  smrd_pkg::cfg_t  cfg,
	output logic            push,
	output smrd_pkg::cls_t  push_data,
	input  logic            push_ready
);
	import smrd_pkg::*;

	assign byte_ch.ready = push_ready;
	assign push          = byte_ch.valid && push_ready;

	always_comb begin
		push_data.raw            = byte_ch.rx_byte;
		push_data.unesc          = unescape(byte_ch.rx_byte);
		push_data.is_end         = (byte_ch.rx_byte == B_END);
		push_data.is_esc         = (byte_ch.rx_byte == B_ESC);
		push_data.is_stdio_start = (byte_ch.rx_byte == cfg.stdio_start_byte);
		push_data.is_coap_start  = (byte_ch.rx_byte == cfg.coap_start_byte);
		push_data.is_net_start   = net_start(byte_ch.rx_byte);
		push_data.coap_can_start = byte_ch.coap_can_start;
		push_data.coap_can_add   = byte_ch.coap_can_add;
		push_data.net_can_start  = byte_ch.net_can_start;
		push_data.net_can_add    = byte_ch.net_can_add;
	end
endmodule
`default_nettype wire

FILE: rtl/core/smrd_fifo.sv
`default_nettype none
`include "slip_mux_receive_deframer_unit_assert.svh"
module smrd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smrd_pkg::cls_t  push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output smrd_pkg::cls_t  pop_data,
	input  logic            pop_ready
);
	import smrd_pkg::*;

	cls_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`SMRD_ASSERT(a_fifo_fill, (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "fifo count did not grow on push")
	`SMRD_ASSERT(a_fifo_drain, (pop && !push) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)), "fifo count did not shrink on pop")
	`SMRD_NEVER(a_fifo_ptrs, (cnt_q == '0) && (wr_ptr_q != rd_ptr_q), "empty fifo with unequal pointers")
endmodule
`default_nettype wire

FILE: rtl/core/smrd_back.sv
`default_nettype none
`include "slip_mux_receive_deframer_unit_assert.svh"
module smrd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  smrd_pkg::cfg_t  cfg,
	input  logic            pop_valid,
	input  smrd_pkg::cls_t  pop_data,
	output logic            pop_ready,
	output logic            res_valid,
	output smrd_pkg::res_t  res,
	input  logic            res_ready
);
	import smrd_pkg::*;

	mode_t mode_q;
	mode_t mode_d;
	res_t  res_d;
	res_t  res_q;
	logic  res_valid_q;
	logic  step;

	logic       in_frame;
	logic       plain;
	logic       en;
	logic       room;
	logic [1:0] fch;
	mode_t      back_mode;
	mode_t      esc_mode;

	assign pop_ready = !res_valid_q || res_ready;
	assign step      = pop_valid && pop_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// CoAP and network frame context
	always_comb begin
		in_frame  = (mode_q == M_COAP) || (mode_q == M_COAP_ESC) ||
		            (mode_q == M_NET) || (mode_q == M_NET_ESC);
		plain     = (mode_q == M_COAP) || (mode_q == M_NET);
		if ((mode_q == M_COAP) || (mode_q == M_COAP_ESC)) begin
			en        = cfg.coap_enable;
			room      = pop_data.coap_can_add;
			fch       = CH_COAP;
			back_mode = M_COAP;
			esc_mode  = M_COAP_ESC;
		end else begin
			en        = cfg.net_enable;
			room      = pop_data.net_can_add;
			fch       = CH_NET;
			back_mode = M_NET;
			esc_mode  = M_NET_ESC;
		end
	end

	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			M_IDLE: begin
				if (pop_data.is_stdio_start) begin
					mode_d = M_TEXT;
				end else if (pop_data.is_coap_start) begin
					if (cfg.coap_enable && !pop_data.coap_can_start)
						mode_d = M_SKIP;
					else
						mode_d = M_COAP;
				end else if (pop_data.is_net_start) begin
					if (cfg.net_enable && (!pop_data.net_can_start || !pop_data.net_can_add))
						mode_d = M_SKIP;
					else
						mode_d = M_NET;
				end else if (!pop_data.is_end) begin
					mode_d = M_SKIP;
				end
			end
			M_SKIP: begin
				if (pop_data.is_end) mode_d = M_IDLE;
			end
			M_TEXT: begin
				if (pop_data.is_esc) mode_d = M_TEXT_ESC;
				else if (pop_data.is_end) mode_d = M_IDLE;
			end
			M_TEXT_ESC: begin
				mode_d = M_TEXT;
			end
			default: begin
				if (plain && pop_data.is_esc) mode_d = esc_mode;
				else if (plain && pop_data.is_end) mode_d = M_IDLE;
				else if (en && !room) mode_d = M_SKIP;
				else mode_d = back_mode;
			end
		endcase
	end

	always_comb begin
		res_d = '0;
		case (mode_q)
			M_IDLE: begin
				if (pop_data.is_stdio_start) begin
					res_d = '0;
				end else if (pop_data.is_coap_start) begin
					if (cfg.coap_enable && pop_data.coap_can_start) begin
						res_d.frame_open = 1'b1;
						res_d.channel    = CH_COAP;
					end
				end else if (pop_data.is_net_start) begin
					if (cfg.net_enable && pop_data.net_can_start) begin
						res_d.frame_open = 1'b1;
						res_d.channel    = CH_NET;
						// first IP byte is payload
						if (pop_data.net_can_add) begin
							res_d.deliver  = 1'b1;
							res_d.out_data = pop_data.raw;
						end else begin
							res_d.frame_drop = 1'b1;
						end
					end
				end
			end
			M_SKIP: begin
				res_d = '0;
			end
			M_TEXT: begin
				if (!pop_data.is_esc && !pop_data.is_end && cfg.stdio_enable) begin
					res_d.deliver  = 1'b1;
					res_d.channel  = CH_TEXT;
					res_d.out_data = pop_data.raw;
				end
			end
			M_TEXT_ESC: begin
				if (cfg.stdio_enable) begin
					res_d.deliver  = 1'b1;
					res_d.channel  = CH_TEXT;
					res_d.out_data = pop_data.unesc;
				end
			end
			default: begin
				if (in_frame && en && !(plain && pop_data.is_esc)) begin
					res_d.channel = fch;
					if (plain && pop_data.is_end) begin
						res_d.frame_commit = 1'b1;
					end else if (room) begin
						res_d.deliver  = 1'b1;
						res_d.out_data = plain ? pop_data.raw : pop_data.unesc;
					end else begin
						res_d.frame_drop = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				mode_q <= mode_d;
			end
			if (pop_ready) begin
				res_valid_q <= pop_valid;
			end
		end
	end

	`SMRD_NEVER(a_deliver_drop, res_valid_q && res_q.deliver && res_q.frame_drop, "deliver and drop in one word")
	`SMRD_NEVER(a_commit_text, res_valid_q && res_q.frame_commit && (res_q.channel == CH_TEXT), "commit on diagnostic channel")
	`SMRD_ASSERT(a_commit_idle, (step && res_d.frame_commit) |=> (mode_q == M_IDLE), "frame not closed after commit")
	`SMRD_ASSERT(a_drop_skip, (step && res_d.frame_drop) |=> (mode_q == M_SKIP), "no skip after drop")
endmodule
`default_nettype wire

FILE: rtl/core/slip_mux_receive_deframer_unit.sv
`default_nettype none
// channel     dir  words
// byte_ch     in   rx_byte plus CoAP/network room flags, valid/ready
// result_ch   out  deliver, channel, out_data, frame_open/commit/drop, valid/ready
// cfg_*       in   register writes, no handshake
//
// One byte per cycle sustained without stalls; the frame mode state machine updates
// once per byte. Bytes are classified into a two-word queue, then the state machine
// fills the output register. No clearing pass after reset; the block starts in idle.
// Either side may stall; the queue and the output register keep the other moving.
module slip_mux_receive_deframer_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	smrd_in_if.sink                               byte_ch,
	smrd_out_if.source                            result_ch,
	input  logic                                  cfg_we,
	input  logic [smrd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [smrd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import smrd_pkg::*;

	cfg_t cfg_q;
	logic push;
	logic push_ready;
	cls_t push_data;
	logic pop_valid;
	logic pop_ready;
	cls_t pop_data;
	logic res_valid;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stdio_enable     <= 1'b1;
			cfg_q.coap_enable      <= 1'b1;
			cfg_q.net_enable       <= 1'b1;
			cfg_q.stdio_start_byte <= 8'd10;
			cfg_q.coap_start_byte  <= 8'd169;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_STDIO_EN:    cfg_q.stdio_enable     <= cfg_wdata[0];
				CFG_COAP_EN:     cfg_q.coap_enable      <= cfg_wdata[0];
				CFG_NET_EN:      cfg_q.net_enable       <= cfg_wdata[0];
				CFG_STDIO_START: cfg_q.stdio_start_byte <= cfg_wdata;
				CFG_COAP_START:  cfg_q.coap_start_byte  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	smrd_front u_front (
		.byte_ch    (byte_ch),
		.cfg        (cfg_q),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	smrd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	smrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (result_ch.ready)
	);

	assign result_ch.valid        = res_valid;
	assign result_ch.deliver      = res.deliver;
	assign result_ch.channel      = res.channel;
	assign result_ch.out_data     = res.out_data;
	assign result_ch.frame_open   = res.frame_open;
	assign result_ch.frame_commit = res.frame_commit;
	assign result_ch.frame_drop   = res.frame_drop;
endmodule
`default_nettype wire
